>>> design/clcu_pkg.sv
`timescale 1ns / 1ps

package clcu_pkg;

	// fixed widths of the channel fields
	localparam int OPCODE_W = 3;
	localparam int DATA_W   = 64;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// defaults for the top-level parameters
	localparam int CAPACITY_DEF   = 64;
	localparam int ITEM_WIDTH_DEF = 64;

	// operation codes
	localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_NEXT   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_PREV   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_LINK,
		ST_UNLINK,
		ST_FETCH,
		ST_LOAD,
		ST_RESP
	} clcu_state_t;

	// write enables of the three node memories
	typedef struct packed {
		logic pay;
		logic nxt;
		logic prv;
	} clcu_node_we_t;

endpackage

>>> design/clcu_cmd_if.sv
`timescale 1ns / 1ps

interface clcu_cmd_if;
	import clcu_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [DATA_W-1:0]   item_data;

	modport source (output valid, output opcode, output item_data, input ready);
	modport sink   (input valid, input opcode, input item_data, output ready);

endinterface

>>> design/clcu_rsp_if.sv
`timescale 1ns / 1ps

interface clcu_rsp_if;
	import clcu_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   current_data;
	logic [COUNT_W-1:0]  node_count;

	modport source (output valid, output status, output current_data, output node_count,
		input ready);
	modport sink   (input valid, input status, input current_data, input node_count,
		output ready);

endinterface

>>> design/clcu_node_mem.sv
`timescale 1ns / 1ps

module clcu_node_mem #(
	parameter int CAPACITY   = clcu_pkg::CAPACITY_DEF,
	parameter int ITEM_WIDTH = clcu_pkg::ITEM_WIDTH_DEF,
	localparam int IW        = $clog2(CAPACITY)
) (
	input  logic                    clk,
	input  clcu_pkg::clcu_node_we_t we,
	input  logic [IW-1:0]           pay_addr,
	input  logic [ITEM_WIDTH-1:0]   pay_wdata,
	output logic [ITEM_WIDTH-1:0]   pay_rdata,
	input  logic [IW-1:0]           nxt_addr,
	input  logic [IW-1:0]           nxt_wdata,
	output logic [IW-1:0]           nxt_rdata,
	input  logic [IW-1:0]           prv_addr,
	input  logic [IW-1:0]           prv_wdata,
	output logic [IW-1:0]           prv_rdata
);
	import clcu_pkg::*;

	logic [ITEM_WIDTH-1:0] pay_mem [CAPACITY];
	logic [IW-1:0]         nxt_mem [CAPACITY];
	logic [IW-1:0]         prv_mem [CAPACITY];

	// single port each: write, or a registered read
	always_ff @(posedge clk) begin
		if (we.pay) begin
			pay_mem[pay_addr] <= pay_wdata;
		end else begin
			pay_rdata <= pay_mem[pay_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we.nxt) begin
			nxt_mem[nxt_addr] <= nxt_wdata;
		end else begin
			nxt_rdata <= nxt_mem[nxt_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we.prv) begin
			prv_mem[prv_addr] <= prv_wdata;
		end else begin
			prv_rdata <= prv_mem[prv_addr];
		end
	end

endmodule

>>> design/clcu_free_stack.sv
`timescale 1ns / 1ps

module clcu_free_stack #(
	parameter int CAPACITY = clcu_pkg::CAPACITY_DEF,
	localparam int IW      = $clog2(CAPACITY),
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic          wr_en,
	input  logic [IW-1:0] addr,
	input  logic [IW-1:0] wdata,
	output logic [IW-1:0] node
);
	import clcu_pkg::*;

	logic [IW-1:0] stack_mem [CAPACITY];
	logic [CW-1:0] mark_q;     // lowest slot ever popped; slots below still hold their index
	logic [IW-1:0] rdata_s1;
	logic [IW-1:0] addr_s1;
	logic          orig_s1;
	logic          below_mark;

	assign below_mark = CW'(addr) < mark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= CW'(CAPACITY);
		end else if (rd_en && below_mark) begin
			mark_q <= CW'(addr);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[addr] <= wdata;
		end else if (rd_en) begin
			rdata_s1 <= stack_mem[addr];
			addr_s1  <= addr;
			orig_s1  <= below_mark;
		end
	end

	// untouched slot reads as its own index
	assign node = orig_s1 ? addr_s1 : rdata_s1;

endmodule

>>> design/circular_list_with_cursor_unit.sv
`timescale 1ns / 1ps
// States after accept: read, any op on an empty list and an insert into a full pool go to RESP;
// insert goes POP, then LINK unless the list was empty; next/previous go FETCH, LOAD; remove
// goes UNLINK, then FETCH, LOAD unless one node was left; all end in RESP. One operation at
// a time; the single-port node memories take the new and neighbor links in separate states.
// Reset (arst_n low, asynchronous): empty list, cursor at node zero, all nodes free,
// no result pending. Node memories and free stack need no clearing pass.

module circular_list_with_cursor_unit #(
	parameter int CAPACITY   = clcu_pkg::CAPACITY_DEF,
	parameter int ITEM_WIDTH = clcu_pkg::ITEM_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	clcu_cmd_if.sink   cmd,
	clcu_rsp_if.source rsp
);
	import clcu_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// control state
	clcu_state_t         state_q, state_nxt;
	logic [CW-1:0]       count_q;
	logic [IW-1:0]       cursor_q;
	logic                rsp_valid_q;

	// payload registers: held op, cached cursor node, result beat
	logic [ITEM_WIDTH-1:0] data_q;
	logic [STATUS_W-1:0]   status_q;
	logic [IW-1:0]         nd_q;
	logic [ITEM_WIDTH-1:0] cur_data_q;
	logic [IW-1:0]         cur_next_q;
	logic [IW-1:0]         cur_prev_q;
	logic [STATUS_W-1:0]   rsp_status_q;
	logic [DATA_W-1:0]     rsp_data_q;
	logic [COUNT_W-1:0]    rsp_count_q;

	// memory ports
	clcu_node_we_t         node_we;
	logic [IW-1:0]         pay_addr, nxt_addr, prv_addr;
	logic [ITEM_WIDTH-1:0] pay_wdata, pay_rdata;
	logic [IW-1:0]         nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;
	logic                  fs_rd, fs_wr;
	logic [IW-1:0]         fs_addr, fs_wdata, fs_node;

	logic          accept;
	logic          empty, full, single;
	logic [CW-1:0] free_top;
	logic          rsp_free;
	logic          is_insert, is_remove, is_step;

	assign accept   = cmd.valid && cmd.ready;
	assign empty    = count_q == '0;
	assign full     = count_q == CW'(CAPACITY);
	assign single   = count_q == CW'(1);
	// free-stack height mirrors the list count
	assign free_top = CW'(CAPACITY) - count_q;
	assign rsp_free = !rsp_valid_q || rsp.ready;

	assign is_insert = cmd.opcode == OP_INSERT;
	assign is_remove = cmd.opcode == OP_REMOVE;
	assign is_step   = (cmd.opcode == OP_NEXT) || (cmd.opcode == OP_PREV);

	// take a new beat only between operations
	assign cmd.ready = state_q == ST_IDLE;

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.current_data = rsp_data_q;
	assign rsp.node_count   = rsp_count_q;

	clcu_node_mem #(
		.CAPACITY   (CAPACITY),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_node_mem (
		.clk       (clk),
		.we        (node_we),
		.pay_addr  (pay_addr),
		.pay_wdata (pay_wdata),
		.pay_rdata (pay_rdata),
		.nxt_addr  (nxt_addr),
		.nxt_wdata (nxt_wdata),
		.nxt_rdata (nxt_rdata),
		.prv_addr  (prv_addr),
		.prv_wdata (prv_wdata),
		.prv_rdata (prv_rdata)
	);

	clcu_free_stack #(
		.CAPACITY (CAPACITY)
	) u_free_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (fs_rd),
		.wr_en  (fs_wr),
		.addr   (fs_addr),
		.wdata  (fs_wdata),
		.node   (fs_node)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_insert) begin
						state_nxt = full ? ST_RESP : ST_POP;
					end else if (empty) begin
						state_nxt = ST_RESP;
					end else if (is_remove) begin
						state_nxt = ST_UNLINK;
					end else if (is_step) begin
						state_nxt = ST_FETCH;
					end else begin
						state_nxt = ST_RESP;
					end
				end
			end
			ST_POP:    state_nxt = empty ? ST_RESP : ST_LINK;
			ST_LINK:   state_nxt = ST_RESP;
			ST_UNLINK: state_nxt = single ? ST_RESP : ST_FETCH;
			ST_FETCH:  state_nxt = ST_LOAD;
			ST_LOAD:   state_nxt = ST_RESP;
			ST_RESP:   state_nxt = rsp_free ? ST_IDLE : ST_RESP;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// memory and stack controls; by default every node memory reads the cursor entry
	always_comb begin
		node_we   = '0;
		pay_addr  = cursor_q;
		nxt_addr  = cursor_q;
		prv_addr  = cursor_q;
		pay_wdata = data_q;
		nxt_wdata = nd_q;
		prv_wdata = nd_q;
		fs_rd     = 1'b0;
		fs_wr     = 1'b0;
		fs_addr   = IW'(free_top - CW'(1));
		fs_wdata  = cursor_q;
		case (state_q)
			ST_IDLE: begin
				// pop: fetch the top of the free stack
				fs_rd = accept && is_insert && !full;
			end
			ST_POP: begin
				// write the new node; on an empty list it links to itself
				node_we   = '{pay: 1'b1, nxt: 1'b1, prv: 1'b1};
				pay_addr  = fs_node;
				nxt_addr  = fs_node;
				prv_addr  = fs_node;
				nxt_wdata = empty ? fs_node : cur_next_q;
				prv_wdata = empty ? fs_node : cursor_q;
			end
			ST_LINK: begin
				// splice: cursor forward to new node, old successor back to it
				node_we  = '{pay: 1'b0, nxt: 1'b1, prv: 1'b1};
				nxt_addr = cursor_q;
				prv_addr = cur_next_q;
			end
			ST_UNLINK: begin
				// bypass the cursor node and push it back on the free stack
				node_we   = '{pay: 1'b0, nxt: !single, prv: !single};
				nxt_addr  = cur_prev_q;
				nxt_wdata = cur_next_q;
				prv_addr  = cur_next_q;
				prv_wdata = cur_prev_q;
				fs_wr     = 1'b1;
				fs_addr   = IW'(free_top);
			end
			default: begin
				node_we = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					// step: move the cursor now, load its node in the fetch
					if (accept && !empty && cmd.opcode == OP_NEXT) begin
						cursor_q <= cur_next_q;
					end else if (accept && !empty && cmd.opcode == OP_PREV) begin
						cursor_q <= cur_prev_q;
					end
				end
				ST_POP: begin
					if (empty) begin
						cursor_q <= fs_node;
						count_q  <= count_q + CW'(1);
					end
				end
				ST_LINK: begin
					cursor_q <= nd_q;
					count_q  <= count_q + CW'(1);
				end
				ST_UNLINK: begin
					// last node gone: cursor drops back to node zero
					cursor_q <= single ? '0 : cur_next_q;
					count_q  <= count_q - CW'(1);
				end
				default: begin
					cursor_q <= cursor_q;
				end
			endcase
			if (state_q == ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					data_q <= cmd.item_data[ITEM_WIDTH-1:0];
					if (is_insert) begin
						status_q <= full ? STS_FULL : STS_OK;
					end else begin
						status_q <= empty ? STS_EMPTY : STS_OK;
					end
				end
			end
			ST_POP: begin
				nd_q <= fs_node;
				if (empty) begin
					cur_data_q <= data_q;
					cur_next_q <= fs_node;
					cur_prev_q <= fs_node;
				end
			end
			ST_LINK: begin
				// new node: successor stays, predecessor is the old cursor
				cur_data_q <= data_q;
				cur_prev_q <= cursor_q;
			end
			ST_LOAD: begin
				cur_data_q <= pay_rdata;
				cur_next_q <= nxt_rdata;
				cur_prev_q <= prv_rdata;
			end
			ST_RESP: begin
				if (rsp_free) begin
					rsp_status_q <= status_q;
					rsp_data_q   <= empty ? '0 : DATA_W'(cur_data_q);
					rsp_count_q  <= COUNT_W'(count_q);
				end
			end
			default: begin
				nd_q <= nd_q;
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list count above capacity");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd.ready)
		else $error("new beat taken while an operation is in flight");

	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STS_EMPTY) |-> (rsp.node_count == '0 &&
			rsp.current_data == '0))
		else $error("empty status with nonzero count or data");

	a_fresh_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LINK) |-> (nd_q != cursor_q && nd_q != cur_next_q))
		else $error("popped node already in the list");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1) ||
			count_q == $past(count_q) - CW'(1)))
		else $error("list count moved by more than one");

endmodule

>>> tb/sv/tb_circular_list_with_cursor_unit.sv
`timescale 1ns / 1ps

module tb_circular_list_with_cursor_unit;
	import clcu_pkg::*;

	localparam int NODES        = CAPACITY_DEF;
	localparam int NODE_W       = $clog2(NODES);
	localparam int PAY_W        = ITEM_WIDTH_DEF;
	localparam logic [DATA_W-1:0] PAY_MASK = (PAY_W >= DATA_W) ? '1 : ((64'd1 << PAY_W) - 64'd1);

	// opcodes past read: the block serves them as a read of the cursor
	localparam logic [OPCODE_W-1:0] OP_RSVD5 = OP_READ + 3'd1;
	localparam logic [OPCODE_W-1:0] OP_RSVD6 = OP_READ + 3'd2;
	localparam logic [OPCODE_W-1:0] OP_RSVD7 = OP_READ + 3'd3;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 3;
	localparam int ITEMS_PER_MIX = 300;
	localparam int MAX_SEND_GAP  = 16;
	localparam int BACKLOG_HOLD  = 400;   // long receiver hold-off, in cycles
	localparam int QUIET_LIMIT   = 3000;  // cycles without any beat before giving up
	localparam int DRAIN_CYCLES  = 8;     // slowest operation is a remove through UNLINK, FETCH and LOAD

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   data;
		logic [COUNT_W-1:0]  count;
	} list_result_t;

	typedef struct {
		logic [OPCODE_W-1:0] op;
		logic [DATA_W-1:0]   data;
		bit                  typed;   // expectation written out below
		list_result_t        want;
	} script_row_t;

	// traffic mixes of the random part
	typedef enum int {MIX_GROW, MIX_WANDER, MIX_SHRINK} op_mix_t;

	logic clk;
	logic arst_n;

	clcu_cmd_if cmd_bus ();
	clcu_rsp_if rsp_bus ();

	circular_list_with_cursor_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus.sink),
		.rsp    (rsp_bus.source)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow of the list: node pool, links, free stack and cursor.
	// ---------------------------------------------------------------
	logic [DATA_W-1:0] node_pay [NODES];
	logic [NODE_W-1:0] node_nxt [NODES];
	logic [NODE_W-1:0] node_prv [NODES];
	logic [NODE_W-1:0] free_pool [NODES];
	int                free_depth;
	logic [NODE_W-1:0] cur;
	int                live_nodes;

	list_result_t expected_results [$];

	int      fail_count;
	int      send_idle_pct;
	int      recv_idle_pct;
	bit      backlog_arm;
	bit      backlog_done;
	int      hold_left;
	int      quiet_cycles;
	op_mix_t mix_mode;
	int      mix_left;

	// Apply one operation to the shadow list and return the beat it must produce.
	function automatic list_result_t apply_list_op(input logic [OPCODE_W-1:0] op,
		input logic [DATA_W-1:0] data);
		list_result_t      r;
		logic [NODE_W-1:0] fresh;
		logic [NODE_W-1:0] succ;
		logic [NODE_W-1:0] pred;
		logic [NODE_W-1:0] gone;
		r.status = STS_OK;
		if (op == OP_INSERT) begin
			if (free_depth == 0) begin
				r.status = STS_FULL;
			end else begin
				// pop a free node and splice it in after the cursor
				free_depth--;
				fresh = free_pool[free_depth];
				node_pay[fresh] = data & PAY_MASK;
				if (live_nodes == 0) begin
					node_nxt[fresh] = fresh;
					node_prv[fresh] = fresh;
				end else begin
					succ = node_nxt[cur];
					node_prv[fresh] = cur;
					node_nxt[fresh] = succ;
					node_nxt[cur]   = fresh;
					node_prv[succ]  = fresh;
				end
				cur = fresh;
				live_nodes++;
			end
		end else if (live_nodes == 0) begin
			r.status = STS_EMPTY;
		end else begin
			case (op)
				OP_REMOVE: begin
					gone = cur;
					succ = node_nxt[gone];
					pred = node_prv[gone];
					if (live_nodes == 1) begin
						// last node leaves: list empty, cursor back home
						cur = '0;
						live_nodes = 0;
					end else begin
						node_nxt[pred] = succ;
						node_prv[succ] = pred;
						cur = succ;
						live_nodes--;
					end
					free_pool[free_depth] = gone;
					free_depth++;
				end
				OP_NEXT: cur = node_nxt[cur];
				OP_PREV: cur = node_prv[cur];
				default: ;
			endcase
		end
		r.data  = (live_nodes == 0) ? '0 : node_pay[cur];
		r.count = live_nodes[COUNT_W-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Command side: offer one beat after a random gap, hold it until
	// the block takes it, then record what the result must be.
	// valid stays high between back-to-back beats.
	// ---------------------------------------------------------------
	task automatic issue_list_op(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] data,
		input bit typed, input list_result_t want);
		int           gap;
		list_result_t predicted;
		gap = 0;
		while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid     <= 1'b1;
		cmd_bus.opcode    <= op;
		cmd_bus.item_data <= data;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		// the shadow always advances; typed rows override what gets checked
		predicted = apply_list_op(op, data);
		expected_results.push_back(typed ? want : predicted);
	endtask

	// Draw an opcode that fits the current traffic mix.
	function automatic logic [OPCODE_W-1:0] draw_op(input op_mix_t mix);
		int roll;
		int ins_top;
		int rem_top;
		roll = $urandom_range(99);
		case (mix)
			MIX_GROW: begin
				ins_top = 70;
				rem_top = 76;
			end
			MIX_SHRINK: begin
				ins_top = 10;
				rem_top = 65;
			end
			default: begin
				ins_top = 25;
				rem_top = 45;
			end
		endcase
		if (roll < ins_top)
			return OP_INSERT;
		if (roll < rem_top)
			return OP_REMOVE;
		if (roll < rem_top + (100 - rem_top) * 4 / 10)
			return OP_NEXT;
		if (roll < rem_top + (100 - rem_top) * 7 / 10)
			return OP_PREV;
		if (roll < 96)
			return OP_READ;
		case ($urandom_range(2))
			0:       return OP_RSVD5;
			1:       return OP_RSVD6;
			default: return OP_RSVD7;
		endcase
	endfunction

	// Random traffic: grow, wander and shrink runs in turn, each a random number of operations long.
	task automatic run_random_ops(input int n);
		logic [DATA_W-1:0] data;
		int                k;
		for (k = 0; k < n; k++) begin
			if (mix_left == 0) begin
				case (mix_mode)
					MIX_GROW:   mix_mode = MIX_WANDER;
					MIX_WANDER: mix_mode = MIX_SHRINK;
					default:    mix_mode = MIX_GROW;
				endcase
				mix_left = (mix_mode == MIX_GROW) ? $urandom_range(100, 160) :
					$urandom_range(40, 120);
			end
			mix_left--;
			case ($urandom_range(9))
				0:       data = '0;
				1:       data = '1;
				default: data = {$urandom, $urandom};
			endcase
			issue_list_op(draw_op(mix_mode), data, 1'b0, '0);
		end
	endtask

	// ---------------------------------------------------------------
	// Result side: check each beat, then pick ready for the next cycle.
	// The long hold-off runs here once it is armed.
	// ---------------------------------------------------------------
	task automatic check_result_beat();
		list_result_t want;
		if (expected_results.size() == 0) begin
			$error("result beat with nothing expected: status %0d data %h count %0d",
				rsp_bus.status, rsp_bus.current_data, rsp_bus.node_count);
			fail_count++;
		end else begin
			want = expected_results.pop_front();
			if (rsp_bus.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, rsp_bus.status);
				fail_count++;
			end
			if (rsp_bus.current_data !== want.data) begin
				$error("current_data: expected %h, got %h", want.data, rsp_bus.current_data);
				fail_count++;
			end
			if (rsp_bus.node_count !== want.count) begin
				$error("node_count: expected %0d, got %0d", want.count, rsp_bus.node_count);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready)
				check_result_beat();
			if (hold_left > 0) begin
				hold_left--;
			end else if (backlog_arm && !backlog_done) begin
				hold_left    = BACKLOG_HOLD;
				backlog_done = 1'b1;
			end
			rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: give up when neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("[circular_list_with_cursor_unit] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Opening script: empty-list answers, single-node wrap, reserved
	// opcodes, extreme payloads, and the last removal emptying the list.
	// ---------------------------------------------------------------
	script_row_t opening_script [22] = '{
		'{OP_READ,   '0, 1'b1, '{STS_EMPTY, '0, '0}},
		'{OP_REMOVE, '0, 1'b1, '{STS_EMPTY, '0, '0}},
		'{OP_NEXT,   '0, 1'b1, '{STS_EMPTY, '0, '0}},
		'{OP_PREV,   '0, 1'b1, '{STS_EMPTY, '0, '0}},
		'{OP_RSVD7,  '1, 1'b1, '{STS_EMPTY, '0, '0}},
		'{OP_INSERT, '1, 1'b1, '{STS_OK, '1, 7'd1}},
		'{OP_READ,   '0, 1'b1, '{STS_OK, '1, 7'd1}},
		'{OP_NEXT,   '0, 1'b1, '{STS_OK, '1, 7'd1}},
		'{OP_PREV,   '0, 1'b1, '{STS_OK, '1, 7'd1}},
		'{OP_INSERT, '0, 1'b1, '{STS_OK, '0, 7'd2}},
		'{OP_NEXT,   '0, 1'b0, '0},
		'{OP_PREV,   '1, 1'b0, '0},
		'{OP_RSVD5,  '0, 1'b0, '0},
		'{OP_RSVD6,  '1, 1'b0, '0},
		'{OP_INSERT, 64'h5555_5555_5555_5555, 1'b1, '{STS_OK, 64'h5555_5555_5555_5555, 7'd3}},
		'{OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{STS_OK, 64'hAAAA_AAAA_AAAA_AAAA, 7'd4}},
		'{OP_REMOVE, '0, 1'b0, '0},
		'{OP_REMOVE, '0, 1'b0, '0},
		'{OP_REMOVE, '0, 1'b0, '0},
		'{OP_REMOVE, '0, 1'b1, '{STS_OK, '0, '0}},
		'{OP_REMOVE, '0, 1'b1, '{STS_EMPTY, '0, '0}},
		'{OP_READ,   '1, 1'b1, '{STS_EMPTY, '0, '0}}
	};

	initial begin
		int i;
		// drive every block input to a known value from time zero
		arst_n            = 1'b0;
		cmd_bus.valid     = 1'b0;
		cmd_bus.opcode    = OP_READ;
		cmd_bus.item_data = '0;
		rsp_bus.ready     = 1'b0;
		fail_count    = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		backlog_arm   = 1'b0;
		backlog_done  = 1'b0;
		hold_left     = 0;
		quiet_cycles  = 0;
		mix_mode      = MIX_SHRINK;   // first advance starts with a grow run
		mix_left      = 0;

		// shadow reset: empty list, cursor at node zero, every node on the free stack
		for (i = 0; i < NODES; i++) begin
			node_pay[i]  = '0;
			node_nxt[i]  = '0;
			node_prv[i]  = '0;
			free_pool[i] = i[NODE_W-1:0];
		end
		free_depth = NODES;
		cur        = '0;
		live_nodes = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// busy sender, sparse receiver
		send_idle_pct = 36;
		recv_idle_pct <= 65;
		foreach (opening_script[i])
			issue_list_op(opening_script[i].op, opening_script[i].data,
				opening_script[i].typed, opening_script[i].want);
		run_random_ops(ITEMS_PER_MIX);

		// sparse sender, busy receiver
		send_idle_pct = 65;
		recv_idle_pct <= 36;
		run_random_ops(ITEMS_PER_MIX);

		// full rate; arm the long hold-off so commands back up behind it
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		backlog_arm   <= 1'b1;
		run_random_ops(ITEMS_PER_MIX);

		cmd_bus.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("[circular_list_with_cursor_unit] OK");
		else
			$display("[circular_list_with_cursor_unit] ERROR");
		$finish;
	end

endmodule
